// File: hdl/sha512_pkg.sv
`timescale 1ns / 1ps
package sha512_pkg;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned WIN_DEPTH   = 16;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned BLOCK_BYTES = 128;
    localparam int unsigned LEN_POS     = 120;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FEED,
        ST_PAD,
        ST_ZERO,
        ST_LEN,
        ST_START,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       feed;
        logic       pad;
        logic       zero;
        logic       lenw;
        logic       start;
        logic       round;
        logic       fold;
        logic       clear;
        logic [6:0] rnd;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic more;
        logic at_len;
        logic hold;
    } t_sts;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    localparam logic [63:0] INIT_HASH [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage

// File: hdl/sha512_if.sv
`timescale 1ns / 1ps
interface sha512_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last;
    modport source (output valid, data_word, valid_bytes, last, input ready);
    modport sink   (input valid, data_word, valid_bytes, last, output ready);
endinterface

interface sha512_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
    modport source (output valid, digest_word, word_index, final_word, input ready);
    modport sink   (input valid, digest_word, word_index, final_word, output ready);
endinterface

// File: hdl/sha512_ctrl.sv
`timescale 1ns / 1ps
module sha512_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [2:0]        o_out_idx,
    input  sha512_pkg::t_sts  i_sts,
    output sha512_pkg::t_cmd  o_cmd
);
    import sha512_pkg::*;

    t_state     r_state, n_state;
    logic [6:0] r_rnd, n_rnd;
    logic       r_fin, n_fin;
    logic       r_padded, n_padded;
    logic       r_lenblk, n_lenblk;
    logic [2:0] r_idx, n_idx;
    logic       w_acc;

    assign w_acc = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rnd    <= '0;
            r_fin    <= 1'b0;
            r_padded <= 1'b0;
            r_lenblk <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_rnd    <= n_rnd;
            r_fin    <= n_fin;
            r_padded <= n_padded;
            r_lenblk <= n_lenblk;
            r_idx    <= n_idx;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_rnd    = r_rnd;
        n_fin    = r_fin;
        n_padded = r_padded;
        n_lenblk = r_lenblk;
        n_idx    = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_fin = i_in_last;
                    if (i_sts.full) begin
                        n_state = ST_START;
                    end else if (i_sts.more) begin
                        n_state = ST_FEED;
                    end else if (i_in_last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_FEED: begin
                if (i_sts.full) begin
                    n_state = ST_START;
                end else if (i_sts.more) begin
                    n_state = ST_FEED;
                end else if (r_fin) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                n_padded = 1'b1;
                if (i_sts.full) begin
                    n_state = ST_START;
                end else if (i_sts.at_len) begin
                    n_state = ST_LEN;
                end else begin
                    n_state = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (i_sts.full) begin
                    n_state = ST_START;
                end else if (i_sts.at_len) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                n_lenblk = 1'b1;
                n_state  = ST_START;
            end
            ST_START: begin
                n_rnd   = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (r_rnd == 7'(ROUNDS - 1)) begin
                    n_rnd   = '0;
                    n_state = ST_FOLD;
                end else begin
                    n_rnd = r_rnd + 7'd1;
                end
            end
            ST_FOLD: begin
                n_idx = '0;
                if (r_lenblk) begin
                    n_state = ST_OUT;
                end else if (i_sts.hold) begin
                    n_state = ST_FEED;
                end else if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (!r_padded) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_ZERO;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state  = ST_IDLE;
                        n_fin    = 1'b0;
                        n_padded = 1'b0;
                        n_lenblk = 1'b0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        o_out_idx   = r_idx;
        o_cmd       = '0;
        o_cmd.rnd   = r_rnd;
        o_cmd.load  = w_acc;
        o_cmd.feed  = (r_state == ST_FEED);
        o_cmd.pad   = (r_state == ST_PAD);
        o_cmd.zero  = (r_state == ST_ZERO);
        o_cmd.lenw  = (r_state == ST_LEN);
        o_cmd.start = (r_state == ST_START);
        o_cmd.round = (r_state == ST_ROUND);
        o_cmd.fold  = (r_state == ST_FOLD);
        o_cmd.clear = (r_state == ST_OUT) && i_out_ready && (r_idx == 3'd7);
    end
endmodule

// File: hdl/sha512_dp.sv
`timescale 1ns / 1ps
module sha512_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [63:0]       i_data_word,
    input  logic [3:0]        i_valid_bytes,
    input  logic [2:0]        i_out_idx,
    input  sha512_pkg::t_cmd  i_cmd,
    output sha512_pkg::t_sts  o_sts,
    output logic [63:0]       o_digest
);
    import sha512_pkg::*;

    logic [63:0] r_h [0:7];
    logic [63:0] r_v [0:7];
    logic [63:0] r_w [0:WIN_DEPTH-1];
    logic [63:0] r_len;
    logic [6:0]  r_fill;
    logic [63:0] r_hold;
    logic [3:0]  r_rem;

    logic        w_ins;
    logic [3:0]  w_cnt, w_room, w_src_cnt, w_k;
    logic [63:0] w_src, w_mask, w_bits;
    logic [7:0]  w_nf;
    logic [63:0] w_x15, w_x2, w_s0, w_s1, w_wn, w_wt;
    logic [63:0] w_t1, w_t2, w_e, w_a;
    logic [3:0]  w_slot, w_ti;
    logic [2:0]  w_off;

    assign w_cnt  = (i_valid_bytes > 4'd8) ? 4'd8 : i_valid_bytes;
    assign w_off  = r_fill[2:0];
    assign w_slot = r_fill[6:3];
    assign w_room = 4'd8 - {1'b0, w_off};
    assign w_ins  = i_cmd.load || i_cmd.feed || i_cmd.pad || i_cmd.zero;

    // Bytes to place come from the input word, the held remainder, the pad
    // byte or zeros up to the end of the current window word.
    always_comb begin
        w_src     = '0;
        w_src_cnt = '0;
        if (i_cmd.load) begin
            w_src     = i_data_word;
            w_src_cnt = w_cnt;
        end else if (i_cmd.feed) begin
            w_src     = r_hold;
            w_src_cnt = r_rem;
        end else if (i_cmd.pad) begin
            w_src     = {PAD_BYTE, 56'd0};
            w_src_cnt = 4'd1;
        end else if (i_cmd.zero) begin
            w_src     = '0;
            w_src_cnt = w_room;
        end
    end

    // Each placement fills at most the rest of the current window word.
    assign w_k    = (w_src_cnt < w_room) ? w_src_cnt : w_room;
    assign w_mask = ~(64'hffffffffffffffff >> {w_k, 3'b000});
    assign w_bits = (w_src & w_mask) >> {w_off, 3'b000};
    assign w_nf   = {1'b0, r_fill} + {4'b0000, w_k};

    assign w_ti  = i_cmd.rnd[3:0];
    assign w_x15 = r_w[w_ti + 4'd1];
    assign w_x2  = r_w[w_ti + 4'd14];
    assign w_s0  = rotr(w_x15, 1) ^ rotr(w_x15, 8) ^ (w_x15 >> 7);
    assign w_s1  = rotr(w_x2, 19) ^ rotr(w_x2, 61) ^ (w_x2 >> 6);
    assign w_wn  = r_w[w_ti] + w_s0 + r_w[w_ti + 4'd9] + w_s1;
    assign w_wt  = (i_cmd.rnd < 7'd16) ? r_w[w_ti] : w_wn;
    assign w_e   = r_v[4];
    assign w_a   = r_v[0];
    assign w_t1  = r_v[7] + (rotr(w_e, 14) ^ rotr(w_e, 18) ^ rotr(w_e, 41))
                 + ((w_e & r_v[5]) ^ (~w_e & r_v[6])) + ROUND_K[i_cmd.rnd] + w_wt;
    assign w_t2  = (rotr(w_a, 28) ^ rotr(w_a, 34) ^ rotr(w_a, 39))
                 + ((w_a & r_v[1]) ^ (w_a & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        o_sts.full   = w_ins && w_nf[7];
        o_sts.more   = w_ins && (w_src_cnt != w_k);
        o_sts.at_len = w_ins && (w_nf == 8'(LEN_POS));
        o_sts.hold   = (r_rem != 4'd0);
    end
    assign o_digest = r_h[i_out_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= INIT_HASH[i];
                r_v[i] <= '0;
            end
            r_len  <= '0;
            r_fill <= '0;
            r_hold <= '0;
            r_rem  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_len <= r_len + {57'd0, w_cnt, 3'b000};
            end
            if (w_ins) begin
                r_fill <= w_nf[6:0];
                r_hold <= w_src << {w_k, 3'b000};
                r_rem  <= w_src_cnt - w_k;
            end
            if (i_cmd.start) begin
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_h[i];
                end
            end
            if (i_cmd.round) begin
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + w_t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= w_t1 + w_t2;
            end
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
        end
    end

    // The window is always written before it is read, so it has no reset.
    always_ff @(posedge i_clk) begin
        if (w_ins && w_k != 4'd0) begin
            if (w_off == 3'd0) begin
                r_w[w_slot] <= w_bits;
            end else begin
                r_w[w_slot] <= r_w[w_slot] | w_bits;
            end
        end
        if (i_cmd.lenw) begin
            r_w[WIN_DEPTH-1] <= r_len;
        end
        if (i_cmd.round && i_cmd.rnd >= 7'd16) begin
            r_w[w_ti] <= w_wn;
        end
    end
endmodule

// File: hdl/sha512_stream_hasher.sv
`timescale 1ns / 1ps
// Channel  Role    Fields
// in_ch    sink    data_word[63:0], valid_bytes[3:0], last
// out_ch   source  digest_word[63:0], word_index[2:0], final_word
//
// A word is taken while idle, and a feed step follows when its bytes straddle two window words.
// A full block holds off the input while it is started, run through 80 rounds and folded.
// The last word adds the pad byte, zero fill at up to eight bytes a cycle
// and the length word, up to two blocks.
// The eight digest items leave one per cycle while out_ch.ready is high.
// Reset is synchronous and active low; it restores the initial hash values.
module sha512_stream_hasher (
    input logic          i_clk,
    input logic          i_rst_n,
    sha512_in_if.sink    in_ch,
    sha512_out_if.source out_ch
);
    import sha512_pkg::*;

    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [2:0] w_out_idx;

    // The controller sequences byte placement, padding, rounds and output.
    sha512_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_last   (in_ch.last),
        .o_in_ready  (in_ch.ready),
        .i_out_ready (out_ch.ready),
        .o_out_valid (out_ch.valid),
        .o_out_idx   (w_out_idx),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the block window, the chaining value and the round unit.
    sha512_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_word   (in_ch.data_word),
        .i_valid_bytes (in_ch.valid_bytes),
        .i_out_idx     (w_out_idx),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_digest      (out_ch.digest_word)
    );

    // The eighth digest item is flagged as the final one.
    assign out_ch.word_index = w_out_idx;
    assign out_ch.final_word = (w_out_idx == 3'd7);

`ifndef ASSERT_OFF
    // A waiting digest item keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.digest_word)
                                          && $stable(out_ch.word_index));
    // The input is never taken while digest items are leaving.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ch.ready && out_ch.valid));
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (out_ch.final_word == (out_ch.word_index == 3'd7)));
`endif
endmodule
